[design/dtc_pkg.sv]
// ----------------------------------------------------------------------------
// dtc_pkg - shared definitions for the dynamic triangle counter
// widths, limits, row geometry and the sequencer state type
// ----------------------------------------------------------------------------
package dtc_pkg;

  // node ids and graph size
  localparam int ID_W    = 8;
  localparam int NODES   = 256;
  localparam int NODE_AW = (NODES > 1) ? $clog2(NODES) : 1;

  // popcount slice taken per cycle
  localparam int CHUNK    = 64;
  localparam int NCHUNK   = (NODES + CHUNK - 1) / CHUNK;
  localparam int PAD_W    = NCHUNK * CHUNK;
  localparam int CNT_W    = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
  localparam int POP_W    = $clog2(CHUNK + 1);
  localparam int SHARED_W = $clog2(NODES);

  // result field widths
  localparam int TRI_W    = 22;
  localparam int SHOUT_W  = 8;
  localparam int EDGE_W   = 15;
  localparam int EVT_W    = 32;

  localparam logic [TRI_W-1:0]  TRI_MAX  = '1;
  localparam logic [EDGE_W-1:0] EDGE_MAX = '1;
  localparam logic [EVT_W-1:0]  EVT_MAX  = '1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_LOAD,
    S_COUNT,
    S_WRA,
    S_WRB,
    S_FIN
  } state_e;

endpackage

[design/dtc_if.sv]
// ----------------------------------------------------------------------------
// dtc_in_if / dtc_out_if - valid/ready channels of the triangle counter
// edge event words in, per-event result words out
// ----------------------------------------------------------------------------
interface dtc_in_if;
  import dtc_pkg::*;

  logic            valid;
  logic            ready;
  logic [ID_W-1:0] node_a;
  logic [ID_W-1:0] node_b;
  logic            is_removal;

  modport source (output valid, output node_a, output node_b, output is_removal,
                  input ready);
  modport sink   (input valid, input node_a, input node_b, input is_removal,
                  output ready);
endinterface

interface dtc_out_if;
  import dtc_pkg::*;

  logic               valid;
  logic               ready;
  logic [TRI_W-1:0]   triangle_total;
  logic [SHOUT_W-1:0] shared_neighbours;
  logic [EDGE_W-1:0]  live_edges;
  logic [EDGE_W-1:0]  peak_edges;
  logic [EVT_W-1:0]   peak_position;
  logic               edge_changed;

  modport source (output valid, output triangle_total, output shared_neighbours,
                  output live_edges, output peak_edges, output peak_position,
                  output edge_changed, input ready);
  modport sink   (input valid, input triangle_total, input shared_neighbours,
                  input live_edges, input peak_edges, input peak_position,
                  input edge_changed, output ready);
endinterface

[design/dynamic_triangle_counter.sv]
// ----------------------------------------------------------------------------
// dynamic_triangle_counter - exact triangle count over a stream of edge events
// adjacency bit matrix in a row memory, one shared popcount slice under a
// small sequencer
// ----------------------------------------------------------------------------
// Each input word names two node ids and an insert/delete flag. The block
// reads both adjacency rows together from a two-read-port row memory,
// ANDs them and counts shared neighbours through one 64-bit popcount slice,
// one slice per cycle. If the event changes the graph, both rows are written
// back (one per cycle) and the count is added to or taken from the triangle
// total. One result word comes out per event, with the triangle total, the
// shared count, live and peak edge counts and the event index of the peak.
// Self-loops and out-of-range ids report zero shared neighbours; redundant
// events report the true count but change nothing. Throughput is one event
// at a time. A graph-changing event steps through the row read, the load,
// the popcount slices, the two row write-backs and the finish step; a
// redundant event skips the write-backs, and a self-loop or out-of-range
// event goes straight from accept to the finish step. A previous result not
// yet taken holds the finish step.
// The input is not ready while an event is in flight; the output register
// lets the next event start while the previous result waits to be taken.
// Row valid bits, cleared by reset, make never-written rows read as zero, so
// no clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module dynamic_triangle_counter (
  input  logic      clk_i,
  input  logic      rst_ni,
  dtc_in_if.sink    in_i,
  dtc_out_if.source out_o
);
  import dtc_pkg::*;

  // adjacency row memory, one row per node
  logic [NODES-1:0] mem [NODES];

  // sequencer
  state_e state_q, state_d;

  // event held while in flight
  logic [NODE_AW-1:0] a_q, b_q;
  logic               rm_q;
  logic               skip_q;      // self-loop or id out of range
  logic               chg_q;       // event alters the edge set

  // row reads and valid bits
  logic [NODES-1:0]   rd_a_q, rd_b_q;
  logic               va_q, vb_q;
  logic [NODES-1:0]   row_vld_q;
  logic [NODES-1:0]   row_a, row_b, row_a_new, row_b_new;

  // popcount
  logic [PAD_W-1:0]    and_q;
  logic [CNT_W-1:0]    cnt_q;
  logic [SHARED_W-1:0] acc_q;

  // running counters
  logic [TRI_W-1:0]  tri_q, tri_d;
  logic [EDGE_W-1:0] edge_q, edge_d;
  logic [EDGE_W-1:0] peak_q;
  logic [EVT_W-1:0]  pidx_q, evt_q;
  logic [TRI_W:0]    tri_sum;

  // result register
  logic               out_valid_q;
  logic [TRI_W-1:0]   o_tri_q;
  logic [SHOUT_W-1:0] o_shared_q;
  logic [EDGE_W-1:0]  o_live_q, o_peak_q;
  logic [EVT_W-1:0]   o_pidx_q;
  logic               o_chg_q;

  logic in_fire, fin_go, ids_ok, last_chunk;

  function automatic logic [POP_W-1:0] pop(input logic [CHUNK-1:0] v);
    logic [POP_W-1:0] n;
    n = '0;
    for (int i = 0; i < CHUNK; i++) n = n + POP_W'(v[i]);
    return n;
  endfunction

  // handshake
  assign in_i.ready = (state_q == S_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign fin_go     = !out_valid_q || out_o.ready;
  assign ids_ok     = (int'(in_i.node_a) < NODES) && (int'(in_i.node_b) < NODES)
                      && (in_i.node_a != in_i.node_b);
  assign last_chunk = (cnt_q == CNT_W'(NCHUNK - 1));

  // rows never written read as empty
  assign row_a = va_q ? rd_a_q : '0;
  assign row_b = vb_q ? rd_b_q : '0;

  always_comb begin
    row_a_new       = row_a;
    row_a_new[b_q]  = !rm_q;
    row_b_new       = row_b;
    row_b_new[a_q]  = !rm_q;
  end

  // counter updates applied in the finish step
  assign tri_sum = {1'b0, tri_q} + (TRI_W + 1)'(acc_q);

  always_comb begin
    tri_d  = tri_q;
    edge_d = edge_q;
    if (!skip_q && chg_q) begin
      if (rm_q) begin
        tri_d  = (tri_q >= TRI_W'(acc_q)) ? tri_q - TRI_W'(acc_q) : '0;
        edge_d = (edge_q != '0) ? edge_q - EDGE_W'(1) : edge_q;
      end else begin
        tri_d  = (tri_sum > (TRI_W + 1)'(TRI_MAX)) ? TRI_MAX : tri_sum[TRI_W-1:0];
        edge_d = (edge_q != EDGE_MAX) ? edge_q + EDGE_W'(1) : edge_q;
      end
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (in_fire) state_d = ids_ok ? S_READ : S_FIN;
      S_READ:  state_d = S_LOAD;
      S_LOAD:  state_d = S_COUNT;
      S_COUNT: if (last_chunk) state_d = chg_q ? S_WRA : S_FIN;
      S_WRA:   state_d = S_WRB;
      S_WRB:   state_d = S_FIN;
      S_FIN:   if (fin_go) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // control and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q   <= '0;
      tri_q       <= '0;
      edge_q      <= '0;
      peak_q      <= '0;
      pidx_q      <= '0;
      evt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (state_q == S_WRA) row_vld_q[a_q] <= 1'b1;
      if (state_q == S_WRB) row_vld_q[b_q] <= 1'b1;
      if (state_q == S_FIN && fin_go) begin
        tri_q       <= tri_d;
        edge_q      <= edge_d;
        if (edge_d > peak_q) begin
          peak_q <= edge_d;
          pidx_q <= evt_q;
        end
        if (evt_q != EVT_MAX) evt_q <= evt_q + EVT_W'(1);
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // event and datapath registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      a_q    <= NODE_AW'(in_i.node_a);
      b_q    <= NODE_AW'(in_i.node_b);
      rm_q   <= in_i.is_removal;
      skip_q <= !ids_ok;
      chg_q  <= 1'b0;
      acc_q  <= '0;
    end
    if (state_q == S_READ) begin
      va_q <= row_vld_q[a_q];
      vb_q <= row_vld_q[b_q];
    end
    if (state_q == S_LOAD) begin
      and_q <= PAD_W'(row_a & row_b);
      cnt_q <= '0;
      chg_q <= rm_q ? row_a[b_q] : !row_a[b_q];
    end
    if (state_q == S_COUNT) begin
      acc_q <= acc_q + SHARED_W'(pop(and_q[CHUNK-1:0]));
      and_q <= and_q >> CHUNK;
      cnt_q <= cnt_q + CNT_W'(1);
    end
    if (state_q == S_FIN && fin_go) begin
      o_tri_q    <= tri_d;
      o_shared_q <= SHOUT_W'(acc_q);
      o_live_q   <= edge_d;
      o_peak_q   <= (edge_d > peak_q) ? edge_d : peak_q;
      o_pidx_q   <= (edge_d > peak_q) ? evt_q : pidx_q;
      o_chg_q    <= !skip_q && chg_q;
    end
  end

  // row memory: two reads, one write
  always_ff @(posedge clk_i) begin
    if (state_q == S_READ) begin
      rd_a_q <= mem[a_q];
      rd_b_q <= mem[b_q];
    end
    if (state_q == S_WRA) mem[a_q] <= row_a_new;
    if (state_q == S_WRB) mem[b_q] <= row_b_new;
  end

  assign out_o.valid             = out_valid_q;
  assign out_o.triangle_total    = o_tri_q;
  assign out_o.shared_neighbours = o_shared_q;
  assign out_o.live_edges        = o_live_q;
  assign out_o.peak_edges        = o_peak_q;
  assign out_o.peak_position     = o_pidx_q;
  assign out_o.edge_changed      = o_chg_q;

`ifndef SYNTHESIS
  // row write-back only for a real change
  a_wr_on_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WRA) |-> (chg_q && !skip_q))
    else $error("row write without edge change");

  // peak never below live count
  a_peak_ge_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    peak_q >= edge_q)
    else $error("peak edge count below live count");

  // event index never goes backwards
  a_evt_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> evt_q >= $past(evt_q))
    else $error("event index decreased");

  // finishing an event always loads a result
  a_fin_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN && fin_go) |=> (out_valid_q && state_q == S_IDLE))
    else $error("finished event produced no result");
`endif

endmodule

[verif/testbench.sv]
// ----------------------------------------------------------------------------
// testbench - self-checking bench for the dynamic triangle counter
// streams insert/delete edge words through the valid/ready channels, keeps a
// mirror of the adjacency matrix and the counters, and checks every result
// word field by field against the mirror, under several idle/stall patterns
// ----------------------------------------------------------------------------
module testbench;
  import dtc_pkg::*;

  localparam int CYCLE_LIMIT  = 150000;
  localparam int DRAIN_CYCLES = 30;
  localparam int HUB_COUNT    = 10;

  // one edge event as it goes into the block
  typedef struct packed {
    logic [ID_W-1:0] node_a;
    logic [ID_W-1:0] node_b;
    logic            is_removal;
  } edge_event_t;

  // one result word as it should come out
  typedef struct packed {
    logic [TRI_W-1:0]   triangle_total;
    logic [SHOUT_W-1:0] shared_neighbours;
    logic [EDGE_W-1:0]  live_edges;
    logic [EDGE_W-1:0]  peak_edges;
    logic [EVT_W-1:0]   peak_position;
    logic               edge_changed;
  } graph_result_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  dtc_in_if  in_bus ();
  dtc_out_if out_bus ();

  dynamic_triangle_counter i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  always #5 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // graph mirror: adjacency rows and the running counters
  // --------------------------------------------------------------------------
  bit [NODES-1:0] adj_rows [NODES];
  int unsigned    tri_count;
  int unsigned    edge_count;
  int unsigned    peak_count;
  int unsigned    peak_index;
  int unsigned    event_count;

  edge_event_t   event_backlog [$];      // words still to be sent
  graph_result_t predicted_results [$];  // results owed by the block, oldest first

  int unsigned sender_idle_pct;
  int unsigned receiver_stall_pct;
  int unsigned mismatch_count;
  int unsigned cycle_count;

  // apply one event to the mirror and return the result word it must produce
  function automatic graph_result_t apply_edge_event(edge_event_t ev);
    graph_result_t r;
    int unsigned   common;
    bit            present;
    r      = '0;
    common = 0;
    if (int'(ev.node_a) < NODES && int'(ev.node_b) < NODES && ev.node_a != ev.node_b) begin
      // shared neighbours are counted before the graph changes
      common  = $countones(adj_rows[ev.node_a] & adj_rows[ev.node_b]);
      present = adj_rows[ev.node_a][ev.node_b];
      if (ev.is_removal && present) begin
        adj_rows[ev.node_a][ev.node_b] = 1'b0;
        adj_rows[ev.node_b][ev.node_a] = 1'b0;
        r.edge_changed = 1'b1;
        tri_count = (tri_count >= common) ? tri_count - common : 0;
        if (edge_count > 0) edge_count--;
      end else if (!ev.is_removal && !present) begin
        adj_rows[ev.node_a][ev.node_b] = 1'b1;
        adj_rows[ev.node_b][ev.node_a] = 1'b1;
        r.edge_changed = 1'b1;
        tri_count = tri_count + common;
        if (tri_count > TRI_MAX) tri_count = 32'(TRI_MAX);
        if (edge_count < EDGE_MAX) edge_count++;
      end
    end
    // peak keeps the index where it was first reached
    if (edge_count > peak_count) begin
      peak_count = edge_count;
      peak_index = event_count;
    end
    if (event_count != 32'hFFFF_FFFF) event_count++;
    r.triangle_total    = tri_count[TRI_W-1:0];
    r.shared_neighbours = common[SHOUT_W-1:0];
    r.live_edges        = edge_count[EDGE_W-1:0];
    r.peak_edges        = peak_count[EDGE_W-1:0];
    r.peak_position     = peak_index;
    return r;
  endfunction

  task automatic check_field(string field, longint unsigned want, longint unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      mismatch_count++;
    end
  endtask

  // --------------------------------------------------------------------------
  // driver: holds a word until taken, then pulls the next one from the backlog
  // --------------------------------------------------------------------------
  edge_event_t   next_word;
  edge_event_t   taken_word;
  graph_result_t taken_result;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_bus.valid      <= 1'b0;
      in_bus.node_a     <= '0;
      in_bus.node_b     <= '0;
      in_bus.is_removal <= 1'b0;
    end else begin
      // the word on the bus was taken at this edge: predict its result now
      if (in_bus.valid && in_bus.ready) begin
        taken_word.node_a     = in_bus.node_a;
        taken_word.node_b     = in_bus.node_b;
        taken_word.is_removal = in_bus.is_removal;
        taken_result          = apply_edge_event(taken_word);
        predicted_results.insert(predicted_results.size(), taken_result);
      end
      if (!in_bus.valid || in_bus.ready) begin
        if (event_backlog.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          next_word          = event_backlog.pop_front();
          in_bus.valid      <= 1'b1;
          in_bus.node_a     <= next_word.node_a;
          in_bus.node_b     <= next_word.node_b;
          in_bus.is_removal <= next_word.is_removal;
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // monitor: random back-pressure, compares each taken word with the oldest
  // prediction
  // --------------------------------------------------------------------------
  graph_result_t owed;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        if (predicted_results.size() == 0) begin
          $display("%0t: unexpected result word, expected none, actual tri %0d shared %0d",
                   $time, out_bus.triangle_total, out_bus.shared_neighbours);
          mismatch_count++;
        end else begin
          owed = predicted_results.pop_front();
          check_field("triangle_total", owed.triangle_total, out_bus.triangle_total);
          check_field("shared_neighbours", owed.shared_neighbours, out_bus.shared_neighbours);
          check_field("live_edges", owed.live_edges, out_bus.live_edges);
          check_field("peak_edges", owed.peak_edges, out_bus.peak_edges);
          check_field("peak_position", owed.peak_position, out_bus.peak_position);
          check_field("edge_changed", owed.edge_changed, out_bus.edge_changed);
        end
      end
      out_bus.ready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, predicted_results.size());
      $display("status: fail");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  task automatic queue_event(int unsigned a, int unsigned b, bit removal);
    edge_event_t ev;
    ev.node_a     = a[ID_W-1:0];
    ev.node_b     = b[ID_W-1:0];
    ev.is_removal = removal;
    event_backlog.insert(event_backlog.size(), ev);
  endtask

  // mostly edges among a small random hub set so triangles build up and get
  // torn down again; the rest is full-range noise and self-loops
  task automatic queue_random_events(int unsigned count);
    bit [ID_W-1:0] hub [HUB_COUNT];
    int unsigned   a;
    int unsigned   b;
    int unsigned   roll;
    for (int i = 0; i < count; i++) begin
      if (i % 55 == 0) begin
        foreach (hub[k]) hub[k] = ID_W'($urandom_range(255));
      end
      roll = $urandom_range(99);
      if (roll < 78) begin
        a = hub[$urandom_range(HUB_COUNT-1)];
        b = hub[$urandom_range(HUB_COUNT-1)];
        // deletions lean up late in each hub window so the graph shrinks too
        queue_event(a, b, $urandom_range(99) < ((i % 55) < 30 ? 20 : 55));
      end else if (roll < 84) begin
        a = $urandom_range(255);
        queue_event(a, a, 1'($urandom_range(1)));
      end else begin
        queue_event($urandom_range(255), $urandom_range(255), 1'($urandom_range(1)));
      end
    end
  endtask

  task automatic wait_backlog_empty();
    while (event_backlog.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    rst_ni             = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: build a four-clique over the extreme ids, redundant events,
    // self-loops, deleting an absent edge, then tear it all down
    queue_event(0, 255, 1'b0);
    queue_event(255, 1, 1'b0);
    queue_event(0, 1, 1'b0);      // closes the first triangle
    queue_event(1, 0, 1'b0);      // already present, nothing changes
    queue_event(7, 7, 1'b0);      // self-loop insert
    queue_event(255, 255, 1'b1);  // self-loop delete
    queue_event(2, 0, 1'b0);
    queue_event(2, 1, 1'b0);
    queue_event(2, 255, 1'b0);    // completes the clique, four triangles
    queue_event(0, 1, 1'b1);      // takes two triangles away
    queue_event(0, 1, 1'b1);      // already gone
    queue_event(128, 64, 1'b1);   // never existed
    queue_event(1, 0, 1'b0);
    queue_event(0, 255, 1'b1);
    queue_event(255, 1, 1'b1);
    queue_event(0, 1, 1'b1);
    queue_event(2, 0, 1'b1);
    queue_event(2, 1, 1'b1);
    queue_event(2, 255, 1'b1);
    queue_event(254, 127, 1'b0);
    queue_event(127, 254, 1'b1);
    wait_backlog_empty();

    // random, one idle pattern per phase
    queue_random_events(165);
    wait_backlog_empty();
    sender_idle_pct = 60;
    queue_random_events(165);
    wait_backlog_empty();
    sender_idle_pct    = 0;
    receiver_stall_pct = 60;
    queue_random_events(165);
    wait_backlog_empty();
    sender_idle_pct    = 14;
    receiver_stall_pct = 14;
    queue_random_events(165);
    wait_backlog_empty();

    // let the last word go in and every result come out
    while (in_bus.valid || predicted_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[filelist.f]
design/dtc_pkg.sv
design/dtc_if.sv
design/dynamic_triangle_counter.sv
verif/testbench.sv
